/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files that check themselves
// no dependencies; each macro names its own clock and active-low reset

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/rpnp_pkg.sv */
// types, character codes and defaults for the number literal parser
// no dependencies; imported by every rtl module of the block

`default_nettype none

package rpnp_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int VALUE_W = 32;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_AT      = 8'h40;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

  typedef enum logic [6:0] {
    PH_FIRST  = 7'b0000001,
    PH_LEAD   = 7'b0000010,
    PH_SIGNED = 7'b0000100,
    PH_ZERO   = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_QUOTE  = 7'b0100000,
    PH_BINARY = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    RX_HEX   = 3'd0,
    RX_DEC   = 3'd1,
    RX_OCT   = 3'd2,
    RX_BIN   = 3'd3,
    RX_QUOTE = 3'd4
  } radix_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } char_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               parse_error;
  } result_t;

endpackage

`default_nettype wire

/* rtl/rpnp_char_if.sv */
// character channel: valid/ready handshake carrying one token character
// depends on rpnp_pkg for the character width

`default_nettype none

interface rpnp_char_if
  import rpnp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/rpnp_result_if.sv */
// result channel: valid/ready handshake carrying a parsed value and error flag
// depends on rpnp_pkg for the value width

`default_nettype none

interface rpnp_result_if
  import rpnp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               parse_error;

  modport source (output valid, output value, output parse_error, input ready);
  modport sink   (input valid, input value, input parse_error, output ready);
endinterface

`default_nettype wire

/* rtl/rpnp_in_stage.sv */
// input register: holds one character beat until the scanner takes it
// depends on rpnp_pkg and rpnp_char_if

`default_nettype none

module rpnp_in_stage
  import rpnp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  rpnp_char_if.sink   in_ch,
  input  wire logic   taken,
  output logic        beat_valid,
  output char_beat_t  beat
);

  logic       valid_r;
  char_beat_t beat_r;

  // refill whenever empty or the held beat leaves this cycle
  assign in_ch.ready = !valid_r || taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      beat_r.char_code <= in_ch.char_code;
      beat_r.is_last   <= in_ch.is_last;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

`default_nettype wire

/* rtl/rpnp_scanner.sv */
// token scanner: per-token state and the combinational step for one character
// depends on rpnp_pkg

`default_nettype none

module rpnp_scanner
  import rpnp_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  beat_valid,
  input  char_beat_t beat,
  input  wire logic  out_space,
  output logic       taken,
  output logic       res_valid,
  output result_t    res
);

  localparam int EXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

  phase_t                phase_r, phase_nxt;
  radix_t                radix_r, radix_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic                  seen_r, seen_nxt;
  logic                  stop_r, stop_nxt;
  logic                  err_r, err_nxt;
  logic [VALUE_BITS-1:0] final_val;
  logic [EXT_W-1:0]      final_ext;
  logic                  final_err;

  // a last beat needs room in the result register, others always pass
  assign taken     = beat_valid && (!beat.is_last || out_space);
  assign res_valid = taken && beat.is_last;

  always_comb begin
    logic [CHAR_W-1:0]     c;
    logic                  run_scan;
    logic                  done;
    phase_t                ph;
    logic [3:0]            dig;
    logic                  dig_ok;
    logic [VALUE_BITS-1:0] scaled;

    c         = beat.char_code;
    run_scan  = 1'b0;
    done      = 1'b0;
    ph        = phase_r;
    dig       = '0;
    dig_ok    = 1'b0;
    scaled    = '0;
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    stop_nxt  = stop_r;
    err_nxt   = err_r;

    unique case (phase_r)
      PH_FIRST: begin
        case (c) inside
          CH_DOLLAR: begin
            radix_nxt = RX_HEX;
            phase_nxt = PH_LEAD;
          end
          CH_DOT: begin
            radix_nxt = RX_DEC;
            phase_nxt = PH_LEAD;
          end
          CH_AT: begin
            radix_nxt = RX_OCT;
            phase_nxt = PH_LEAD;
          end
          CH_QUOTE, CH_DQUOTE: begin
            radix_nxt = RX_QUOTE;
            phase_nxt = PH_QUOTE;
          end
          CH_PCT: begin
            radix_nxt = RX_BIN;
            phase_nxt = PH_BINARY;
          end
          default: begin
            // no prefix: the character itself starts a hex number
            radix_nxt = RX_HEX;
            phase_nxt = PH_LEAD;
            run_scan  = 1'b1;
          end
        endcase
      end
      PH_QUOTE: begin
        if (!stop_r) begin
          acc_nxt  = VALUE_BITS'(c);
          stop_nxt = 1'b1;
        end
      end
      PH_BINARY: begin
        if (!stop_r) begin
          if (c == CH_NUL) begin
            stop_nxt = 1'b1;
          end else begin
            acc_nxt = {acc_r[VALUE_BITS-2:0], (c == CH_ONE)};
            if (c != CH_ONE && c != CH_ZERO) begin
              err_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end
          end
        end
      end
      PH_LEAD, PH_SIGNED, PH_ZERO, PH_DIGITS: begin
        run_scan = !stop_r;
      end
      default: begin
        run_scan = 1'b0;
      end
    endcase

    // digit value against the radix in force for this character
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dig    = 4'(c - CH_ZERO);
      dig_ok = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      dig    = 4'(c - CH_LOWER_A + 8'd10);
      dig_ok = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      dig    = 4'(c - CH_UPPER_A + 8'd10);
      dig_ok = 1'b1;
    end
    case (radix_nxt)
      RX_DEC: begin
        scaled = (acc_r << 3) + (acc_r << 1);
        if (dig > 4'd9) dig_ok = 1'b0;
      end
      RX_OCT: begin
        scaled = acc_r << 3;
        if (dig > 4'd7) dig_ok = 1'b0;
      end
      default: begin
        scaled = acc_r << 4;
      end
    endcase

    if (run_scan) begin
      ph = phase_nxt;
      if (ph == PH_LEAD) begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          done = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_nxt = (c == CH_MINUS);
          ph      = PH_SIGNED;
          done    = 1'b1;
        end else begin
          ph = PH_SIGNED;
        end
      end
      if (!done && ph == PH_SIGNED) begin
        if (radix_nxt == RX_HEX && c == CH_ZERO) begin
          acc_nxt  = scaled;
          seen_nxt = 1'b1;
          ph       = PH_ZERO;
          done     = 1'b1;
        end else begin
          ph = PH_DIGITS;
        end
      end
      if (!done && ph == PH_ZERO) begin
        ph = PH_DIGITS;
        if (c == CH_LOWER_X || c == CH_UPPER_X) done = 1'b1;
      end
      if (!done) begin
        if (dig_ok) begin
          acc_nxt  = scaled + VALUE_BITS'(dig);
          seen_nxt = 1'b1;
        end else begin
          stop_nxt = 1'b1;
        end
      end
      phase_nxt = ph;
    end
  end

  // result from the updated token state
  always_comb begin
    final_val = acc_nxt;
    final_err = 1'b0;
    case (radix_nxt)
      RX_BIN:   final_err = err_nxt;
      RX_QUOTE: final_err = 1'b0;
      default: begin
        if (!seen_nxt) begin
          final_val = '0;
          final_err = 1'b1;
        end else if (neg_nxt) begin
          final_val = '0 - acc_nxt;
        end
      end
    endcase
    final_ext       = EXT_W'(final_val);
    res.value       = final_ext[VALUE_W-1:0];
    res.parse_error = final_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r <= PH_FIRST;
      radix_r <= RX_HEX;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      stop_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (taken) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      stop_r  <= stop_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rpnp_out_stage.sv */
// result register: holds one parsed value until the receiver takes it
// depends on rpnp_pkg and rpnp_result_if

`default_nettype none

module rpnp_out_stage
  import rpnp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  result_t      res,
  output logic         space,
  rpnp_result_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign space = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.value       = res_r.value;
  assign out_ch.parse_error = res_r.parse_error;

endmodule

`default_nettype wire

/* rtl/radix_prefixed_number_parser.sv */
// Number literal parser: turns a token of ASCII characters into a binary value.
// Input channel in_ch: one character per beat, is_last set on the final one.
// Output channel out_ch: one beat per token, carrying value and parse_error.
// The first character picks the radix ('$' or none hex, '.' decimal,
// '@' octal, '%' binary, a quote takes the next byte); hex, decimal and
// octal skip blanks, take one sign, and stop at the first non-digit.
// Throughput: one character per cycle, sustained while the result register has
// room; the single scan step sits between the input and token state registers.
// A last character waits in the input register, is scanned into the result
// register, and is then offered to the receiver on out_ch.
// When the receiver stalls, non-final characters keep flowing into the
// token state; a final character waits in the input register until the
// result register frees, so at most one token result is buffered.
// Reset (rst_n low, synchronous) empties both registers and returns the
// scanner to the start of a token.
// Depends on rpnp_pkg, the two channel interfaces, the three submodules and assert_macros.svh.

`default_nettype none

module radix_prefixed_number_parser
  import rpnp_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rpnp_char_if.sink     in_ch,
  rpnp_result_if.source out_ch
);

`include "assert_macros.svh"

  logic       beat_valid;
  char_beat_t beat;
  logic       taken;
  logic       res_valid;
  result_t    res;
  logic       out_space;

  rpnp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .taken      (taken),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  rpnp_scanner #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_space  (out_space),
    .taken      (taken),
    .res_valid  (res_valid),
    .res        (res)
  );

  rpnp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res    (res),
    .space  (out_space),
    .out_ch (out_ch)
  );

  // a waiting character beat is neither dropped nor altered
  `ASSERT_NEXT(a_beat_held, clk, rst_n, beat_valid && !taken, beat_valid && $stable(beat))
  // a result never lands on one the receiver has not taken
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, res_valid, !out_ch.valid || out_ch.ready)
  // every scanned token shows up on the output in the following cycle
  `ASSERT_NEXT(a_result_shown, clk, rst_n, res_valid, out_ch.valid)

endmodule

`default_nettype wire
